// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// shared constants, types and bracket decode for the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] VERDICT_PENDING    = 3'd0;
	localparam logic [2:0] VERDICT_BALANCED   = 3'd1;
	localparam logic [2:0] VERDICT_MORE_RIGHT = 3'd2;
	localparam logic [2:0] VERDICT_MISMATCH   = 3'd3;
	localparam logic [2:0] VERDICT_MORE_LEFT  = 3'd4;
	localparam logic [2:0] VERDICT_OVERFLOW   = 3'd5;

	localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
	localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b;
	localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b;
	localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
	localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d;

	// shift command handed to every stack cell
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] kind;
	} shift_cmd_t;

	// one result item
	typedef struct packed {
		logic [2:0] verdict;
		logic [7:0] nesting_depth;
	} result_t;

	function automatic logic [1:0] opener_kind(input logic [7:0] c);
		logic [1:0] k;
		case (c)
			CHAR_OPEN_PAREN:  k = 2'd0;
			CHAR_OPEN_SQUARE: k = 2'd1;
			CHAR_OPEN_CURLY:  k = 2'd2;
			default:          k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [1:0] closer_kind(input logic [7:0] c);
		logic [1:0] k;
		case (c)
			CHAR_CLOSE_PAREN:  k = 2'd0;
			CHAR_CLOSE_SQUARE: k = 2'd1;
			CHAR_CLOSE_CURLY:  k = 2'd2;
			default:           k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/bbc_cell.sv =====
// ----------------------------------------------------------------------------
// bbc_cell
// one stack slot; shifts toward the bottom on push, toward the top on pop
// ----------------------------------------------------------------------------
module bbc_cell (
	input  logic               clk,
	input  bbc_pkg::shift_cmd_t cmd,
	input  logic [1:0]         from_above,
	input  logic [1:0]         from_below,
	output logic [1:0]         kind
);

	logic [1:0] kind_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kind_q <= from_above;
		end else if (cmd.pop) begin
			kind_q <= from_below;
		end
	end

	assign kind = kind_q;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl
// bracket decode, fill count, sticky error and verdict
// ----------------------------------------------------------------------------
module bbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  logic [1:0]          top_kind,
	output bbc_pkg::shift_cmd_t cmd,
	output bbc_pkg::result_t    result
);

	logic [bbc_pkg::FILL_W-1:0] fill_q;
	logic [2:0]                 err_q;

	logic [1:0]                 ok;
	logic [1:0]                 ck;
	logic [bbc_pkg::FILL_W-1:0] fill_nx;
	logic [2:0]                 err_nx;
	logic [2:0]                 verdict_nx;
	logic                       push;
	logic                       pop;
	logic [bbc_pkg::FILL_W+7:0] depth_ext;

	assign ok = bbc_pkg::opener_kind(char_code);
	assign ck = bbc_pkg::closer_kind(char_code);

	always_comb begin
		fill_nx = fill_q;
		err_nx  = err_q;
		push    = 1'b0;
		pop     = 1'b0;
		if (err_q == bbc_pkg::VERDICT_PENDING) begin
			if (ok != bbc_pkg::KIND_NONE) begin
				if (fill_q == bbc_pkg::FILL_W'(bbc_pkg::STACK_DEPTH)) begin
					err_nx = bbc_pkg::VERDICT_OVERFLOW;
				end else begin
					push    = 1'b1;
					fill_nx = fill_q + 1'b1;
				end
			end else if (ck != bbc_pkg::KIND_NONE) begin
				if (fill_q == '0) begin
					err_nx = bbc_pkg::VERDICT_MORE_RIGHT;
				end else begin
					pop     = 1'b1;
					fill_nx = fill_q - 1'b1;
					if (top_kind != ck) begin
						err_nx = bbc_pkg::VERDICT_MISMATCH;
					end
				end
			end
		end
	end

	assign depth_ext            = {8'd0, fill_nx};
	assign result.nesting_depth = depth_ext[7:0];

	always_comb begin
		if (!last_char) begin
			verdict_nx = bbc_pkg::VERDICT_PENDING;
		end else if (err_nx != bbc_pkg::VERDICT_PENDING) begin
			verdict_nx = err_nx;
		end else if (fill_nx == '0) begin
			verdict_nx = bbc_pkg::VERDICT_BALANCED;
		end else begin
			verdict_nx = bbc_pkg::VERDICT_MORE_LEFT;
		end
	end

	assign result.verdict = verdict_nx;

	assign cmd.push = accept & push;
	assign cmd.pop  = accept & pop;
	assign cmd.kind = ok;

	// the last item of a string leaves the block clean for the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			err_q  <= bbc_pkg::VERDICT_PENDING;
		end else if (accept) begin
			if (last_char) begin
				fill_q <= '0;
				err_q  <= bbc_pkg::VERDICT_PENDING;
			end else begin
				fill_q <= fill_nx;
				err_q  <= err_nx;
			end
		end
	end

endmodule

// ===== rtl/bbc_out_buf.sv =====
// ----------------------------------------------------------------------------
// bbc_out_buf
// output register with a skid stage so one more input is taken under a stall
// ----------------------------------------------------------------------------
module bbc_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bbc_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output bbc_pkg::result_t out_data
);

	logic             main_valid_q;
	logic             skid_valid_q;
	bbc_pkg::result_t main_q;
	bbc_pkg::result_t skid_q;
	logic             take;
	logic             give;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid & ~skid_valid_q;
	assign give      = main_valid_q & ~out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (give) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take) begin
			if (main_valid_q && !give) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (give) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (give) begin
				main_q <= skid_q;
			end
		end else if (take) begin
			if (main_valid_q && !give) begin
				skid_q <= in_data;
			end else begin
				main_q <= in_data;
			end
		end
	end

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks bracket balance of a byte stream; the stack is a row of shift cells
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  char     input      char_valid, char_stall, char_code[7:0], last_char
//  result   output     result_valid, result_stall, verdict[2:0], nesting_depth[7:0]
//
//  one item per cycle while char_stall is low; each item gives one result item via the output buffer
//  a push or pop shifts the whole cell row in the same cycle, top at cell 0
//  reset clears the fill count, the sticky error and the output buffer
//  a two-entry output buffer absorbs one stalled result before char_stall rises
// ----------------------------------------------------------------------------
module bracket_balance_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] verdict,
	output logic [7:0] nesting_depth
);

	localparam int DEPTH = bbc_pkg::STACK_DEPTH;

	bbc_pkg::shift_cmd_t cmd;
	bbc_pkg::result_t    res;
	bbc_pkg::result_t    res_out;
	logic                accept;
	logic [1:0]          cell_kind [DEPTH];

	assign accept = char_valid & ~char_stall;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.last_char (last_char),
		.top_kind  (cell_kind[0]),
		.cmd       (cmd),
		.result    (res)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [1:0] above;
		logic [1:0] below;
		if (i == 0) begin : g_top
			assign above = cmd.kind;
		end else begin : g_mid
			assign above = cell_kind[i-1];
		end
		// bottom cell keeps its own value on pop; it is beyond the fill then
		if (i == DEPTH - 1) begin : g_bot
			assign below = cell_kind[i];
		end else begin : g_up
			assign below = cell_kind[i+1];
		end
		bbc_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.from_above (above),
			.from_below (below),
			.kind       (cell_kind[i])
		);
	end

	bbc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_valid),
		.in_stall  (char_stall),
		.in_data   (res),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (res_out)
	);

	assign verdict       = res_out.verdict;
	assign nesting_depth = res_out.nesting_depth;

endmodule

// ===== bench/bracket_balance_checker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_tb
// streams bracket strings into the checker and compares every result item
// against a scoreboard model of the bracket stack (or a typed row); a short directed table
// comes first, then random strings under three idling mixes
// ----------------------------------------------------------------------------
module bracket_balance_checker_tb;

	localparam logic [1:0] KIND_PAREN  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;

	localparam logic [1:0] CLS_OTHER = 2'd0;
	localparam logic [1:0] CLS_OPEN  = 2'd1;
	localparam logic [1:0] CLS_CLOSE = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;

	localparam int HOLD_CYCLES = 60;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       known;
		logic [2:0] v;
		logic [7:0] d;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic [7:0] char_code = 8'h00;
	logic       last_char = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [2:0] verdict;
	logic [7:0] nesting_depth;

	bracket_balance_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.last_char     (last_char),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.verdict       (verdict),
		.nesting_depth (nesting_depth)
	);

	always #5 clk = ~clk;

	// directed table: expectation typed in only where it is obvious
	row_t directed_rows [0:24] = '{
		'{bbc_pkg::CHAR_CLOSE_PAREN,  1'b1, 1'b1, bbc_pkg::VERDICT_MORE_RIGHT, 8'd0},
		'{bbc_pkg::CHAR_OPEN_PAREN,   1'b1, 1'b1, bbc_pkg::VERDICT_MORE_LEFT,  8'd1},
		'{8'h00,                      1'b1, 1'b1, bbc_pkg::VERDICT_BALANCED,   8'd0},
		'{8'hff,                      1'b1, 1'b1, bbc_pkg::VERDICT_BALANCED,   8'd0},
		'{bbc_pkg::CHAR_OPEN_PAREN,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{bbc_pkg::CHAR_OPEN_SQUARE,  1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd2},
		'{bbc_pkg::CHAR_OPEN_CURLY,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd3},
		'{bbc_pkg::CHAR_CLOSE_CURLY,  1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd2},
		'{bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{bbc_pkg::CHAR_CLOSE_PAREN,  1'b1, 1'b1, bbc_pkg::VERDICT_BALANCED,   8'd0},
		'{bbc_pkg::CHAR_OPEN_PAREN,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{bbc_pkg::CHAR_CLOSE_SQUARE, 1'b1, 1'b1, bbc_pkg::VERDICT_MISMATCH,   8'd0},
		'{bbc_pkg::CHAR_OPEN_CURLY,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{bbc_pkg::CHAR_OPEN_CURLY,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd2},
		'{bbc_pkg::CHAR_CLOSE_PAREN,  1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{bbc_pkg::CHAR_OPEN_PAREN,   1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd1},
		'{8'hff,                      1'b1, 1'b1, bbc_pkg::VERDICT_MISMATCH,   8'd1},
		'{bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd0},
		'{bbc_pkg::CHAR_OPEN_SQUARE,  1'b0, 1'b1, bbc_pkg::VERDICT_PENDING,    8'd0},
		'{bbc_pkg::CHAR_CLOSE_SQUARE, 1'b1, 1'b1, bbc_pkg::VERDICT_MORE_RIGHT, 8'd0},
		'{bbc_pkg::CHAR_OPEN_SQUARE,  1'b0, 1'b0, bbc_pkg::VERDICT_PENDING,    8'd0},
		'{8'h61,                      1'b0, 1'b0, bbc_pkg::VERDICT_PENDING,    8'd0},
		'{bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0, 1'b0, bbc_pkg::VERDICT_PENDING,    8'd0},
		'{bbc_pkg::CHAR_OPEN_CURLY,   1'b1, 1'b1, bbc_pkg::VERDICT_MORE_LEFT,  8'd1},
		'{bbc_pkg::CHAR_CLOSE_CURLY,  1'b1, 1'b1, bbc_pkg::VERDICT_MORE_RIGHT, 8'd0}
	};

	// scoreboard model of the bracket stack
	logic [1:0] kinds_held [0:bbc_pkg::STACK_DEPTH-1];
	int         held_count = 0;
	logic [2:0] sticky_err = ERR_NONE;

	bbc_pkg::result_t due_results [$];
	row_t             row_fifo [$];
	logic [7:0]       str_q [$];

	int send_gap_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;

	int items_sent = 0;
	int strings_sent = 0;
	int results_seen = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int deepest = 0;
	int verdict_tally [0:7] = '{default: 0};

	function automatic logic [1:0] classify(input logic [7:0] c, output logic [1:0] kind);
		kind = bbc_pkg::KIND_NONE;
		case (c)
		bbc_pkg::CHAR_OPEN_PAREN:   begin kind = KIND_PAREN;  return CLS_OPEN;  end
		bbc_pkg::CHAR_OPEN_SQUARE:  begin kind = KIND_SQUARE; return CLS_OPEN;  end
		bbc_pkg::CHAR_OPEN_CURLY:   begin kind = KIND_CURLY;  return CLS_OPEN;  end
		bbc_pkg::CHAR_CLOSE_PAREN:  begin kind = KIND_PAREN;  return CLS_CLOSE; end
		bbc_pkg::CHAR_CLOSE_SQUARE: begin kind = KIND_SQUARE; return CLS_CLOSE; end
		bbc_pkg::CHAR_CLOSE_CURLY:  begin kind = KIND_CURLY;  return CLS_CLOSE; end
		default:                    return CLS_OTHER;
		endcase
	endfunction

	function automatic logic [7:0] bracket_char(input logic [1:0] kind, input logic closing);
		case (kind)
		KIND_PAREN:  return closing ? bbc_pkg::CHAR_CLOSE_PAREN : bbc_pkg::CHAR_OPEN_PAREN;
		KIND_SQUARE: return closing ? bbc_pkg::CHAR_CLOSE_SQUARE : bbc_pkg::CHAR_OPEN_SQUARE;
		default:     return closing ? bbc_pkg::CHAR_CLOSE_CURLY : bbc_pkg::CHAR_OPEN_CURLY;
		endcase
	endfunction

	// advances the stack model by one char and returns the result it causes
	function automatic bbc_pkg::result_t judge_char(input logic [7:0] c, input logic fin);
		bbc_pkg::result_t r;
		logic [1:0]       cls;
		logic [1:0]       kind;
		cls = classify(c, kind);
		if (sticky_err == ERR_NONE) begin
			if (cls == CLS_OPEN) begin
				if (held_count >= bbc_pkg::STACK_DEPTH)
					sticky_err = bbc_pkg::VERDICT_OVERFLOW;
				else begin
					kinds_held[held_count] = kind;
					held_count++;
				end
			end else if (cls == CLS_CLOSE) begin
				if (held_count == 0)
					sticky_err = bbc_pkg::VERDICT_MORE_RIGHT;
				else begin
					// wrong kind still pops
					held_count--;
					if (kinds_held[held_count] != kind)
						sticky_err = bbc_pkg::VERDICT_MISMATCH;
				end
			end
		end
		r.nesting_depth = held_count[7:0];
		r.verdict = bbc_pkg::VERDICT_PENDING;
		if (fin) begin
			if (sticky_err != ERR_NONE)
				r.verdict = sticky_err;
			else if (held_count == 0)
				r.verdict = bbc_pkg::VERDICT_BALANCED;
			else
				r.verdict = bbc_pkg::VERDICT_MORE_LEFT;
			held_count = 0;
			sticky_err = ERR_NONE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	// scoreboard: input side first so a same-edge result still finds its item
	always @(posedge clk) begin
		row_t             row;
		bbc_pkg::result_t want;
		logic             in_taken;
		logic             out_taken;
		in_taken = arst_n && char_valid && !char_stall;
		out_taken = arst_n && result_valid && !result_stall;
		if (in_taken) begin
			want = judge_char(char_code, last_char);
			row = (row_fifo.size() != 0) ? row_fifo.pop_front() : '0;
			if (row.known) begin
				want.verdict = row.v;
				want.nesting_depth = row.d;
			end
			due_results.push_back(want);
		end
		if (out_taken) begin
			results_seen++;
			verdict_tally[verdict]++;
			if (int'(nesting_depth) > deepest)
				deepest = int'(nesting_depth);
			if (due_results.size() == 0)
				report_mismatch("unexpected result item, verdict", int'(verdict), 0);
			else begin
				want = due_results.pop_front();
				if (verdict !== want.verdict)
					report_mismatch("verdict", int'(verdict), int'(want.verdict));
				if (nesting_depth !== want.nesting_depth)
					report_mismatch("nesting_depth", int'(nesting_depth),
						int'(want.nesting_depth));
			end
		end
		quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_char(input row_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		row_fifo.push_back(r);
		char_valid <= 1'b1;
		char_code <= r.ch;
		last_char <= r.fin;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_string();
		row_t r;
		for (int i = 0; i < str_q.size(); i++) begin
			r = '0;
			r.ch = str_q[i];
			r.fin = (i == str_q.size() - 1);
			send_char(r);
		end
		strings_sent++;
	endtask

	task automatic wait_all_due();
		char_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		logic [1:0] kind;
		do
			c = 8'($urandom_range(255));
		while (classify(c, kind) != CLS_OTHER);
		return c;
	endfunction

	// balanced string with random nesting and filler bytes
	function automatic void build_nested(input int len);
		logic [1:0] open_q [$];
		logic [1:0] kind;
		str_q.delete();
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(2))
			0: begin
				kind = 2'($urandom_range(2));
				open_q.push_back(kind);
				str_q.push_back(bracket_char(kind, 1'b0));
			end
			1: begin
				if (open_q.size() != 0)
					str_q.push_back(bracket_char(open_q.pop_back(), 1'b1));
				else
					str_q.push_back(noise_char());
			end
			default: str_q.push_back(noise_char());
			endcase
		end
		while (open_q.size() != 0)
			str_q.push_back(bracket_char(open_q.pop_back(), 1'b1));
		if (str_q.size() == 0)
			str_q.push_back(noise_char());
	endfunction

	function automatic void break_string();
		int at;
		at = $urandom_range(str_q.size() - 1);
		case ($urandom_range(3))
		0: str_q[at] = bracket_char(2'($urandom_range(2)), 1'($urandom_range(1)));
		1: str_q.push_back(bracket_char(2'($urandom_range(2)), 1'b1));
		2: begin
			if (str_q.size() > 1)
				str_q.delete(at);
		end
		default: str_q.insert(at, bracket_char(2'($urandom_range(2)), 1'b0));
		endcase
	endfunction

	function automatic void build_noise(input int len);
		str_q.delete();
		for (int i = 0; i < len; i++)
			str_q.push_back(8'($urandom_range(255)));
	endfunction

	// runs of openers up to and past a full stack, then matching closers
	function automatic void build_deep(input int opens, input int closes);
		logic [1:0] open_q [$];
		logic [1:0] kind;
		str_q.delete();
		for (int i = 0; i < opens; i++) begin
			kind = 2'($urandom_range(2));
			open_q.push_back(kind);
			str_q.push_back(bracket_char(kind, 1'b0));
		end
		for (int i = 0; i < closes && open_q.size() != 0; i++)
			str_q.push_back(bracket_char(open_q.pop_back(), 1'b1));
	endfunction

	task automatic run_random(input int budget);
		int goal;
		int pick;
		int opens;
		goal = items_sent + budget;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 60)
				build_nested($urandom_range(1, 24));
			else if (pick < 85) begin
				build_nested($urandom_range(1, 24));
				break_string();
			end else if (pick < 97)
				build_noise($urandom_range(1, 6));
			else begin
				opens = $urandom_range(120, 132);
				build_deep(opens, $urandom_range(0, opens));
			end
			send_string();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 25;
		stall_pct = 64;
		foreach (directed_rows[i])
			send_char(directed_rows[i]);
		wait_all_due();

		// receiver holds off while strings keep coming, so the input backs up
		hold_req = 1'b1;
		run_random(350);
		wait_all_due();

		send_gap_pct = 64;
		stall_pct = 25;
		run_random(350);
		wait_all_due();

		send_gap_pct = 0;
		stall_pct = 0;
		build_deep(bbc_pkg::STACK_DEPTH, bbc_pkg::STACK_DEPTH);
		send_string();
		build_deep(bbc_pkg::STACK_DEPTH + 1, 10);
		send_string();
		build_deep(bbc_pkg::STACK_DEPTH, 0);
		send_string();
		run_random(350);
		wait_all_due();

		repeat (8) @(posedge clk);
		$display("checked %0d result items from %0d items, %0d strings, deepest nesting %0d",
			results_seen, items_sent, strings_sent, deepest);
		$display("verdicts: balanced %0d, more right %0d, mismatch %0d, more left %0d, overflow %0d",
			verdict_tally[bbc_pkg::VERDICT_BALANCED],
			verdict_tally[bbc_pkg::VERDICT_MORE_RIGHT],
			verdict_tally[bbc_pkg::VERDICT_MISMATCH],
			verdict_tally[bbc_pkg::VERDICT_MORE_LEFT],
			verdict_tally[bbc_pkg::VERDICT_OVERFLOW]);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== bracket_balance_checker.f =====
rtl/bbc_pkg.sv
rtl/bbc_cell.sv
rtl/bbc_ctrl.sv
rtl/bbc_out_buf.sv
rtl/bracket_balance_checker.sv
bench/bracket_balance_checker_tb.sv
